/* hdl/variable_length_byte_stack_core_defines.svh */
// Assertion macros shared by the record stack RTL.
// Included by modules that carry concurrent assertions; depends on nothing.
`ifndef VARIABLE_LENGTH_BYTE_STACK_CORE_DEFINES_SVH
`define VARIABLE_LENGTH_BYTE_STACK_CORE_DEFINES_SVH

// Condition holds in the same cycle as its antecedent.
`define VLBS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("record stack check failed");

// Condition holds in the cycle after its antecedent.
`define VLBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("record stack check failed");

`endif

/* hdl/vlbs_pkg.sv */
// Types and constants of the variable-length record stack.
// Used by vlbs_store and variable_length_byte_stack_core; depends on nothing.
`timescale 1ns / 1ps

package vlbs_pkg;

   // Sizing of the store and of one record.
   localparam int STACK_BYTES      = 1024;
   localparam int LEN_WORD_BYTES   = 4;
   localparam int MAX_RECORD_BYTES = 8;

   localparam int ADDR_W = $clog2(STACK_BYTES);
   localparam int TOP_W  = $clog2(STACK_BYTES + 1);
   localparam int FIT_W  = TOP_W + 1;
   localparam int LEN_W  = 4;
   localparam int CNT_W  = $clog2(MAX_RECORD_BYTES + LEN_WORD_BYTES + 1);
   localparam int IDX_W  = $clog2(MAX_RECORD_BYTES);
   localparam int DATA_W = 64;
   localparam int CMD_W  = 3;
   localparam int STS_W  = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CHECK = 3'd4;

   // Result status codes.
   localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
   localparam logic [STS_W-1:0] STS_NO_ROOM = 2'd1;
   localparam logic [STS_W-1:0] STS_EMPTY   = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_LEN_RD,
      ST_LEN_WAIT,
      ST_DATA,
      ST_FINISH
   } state_type;

   // One access to the byte store.
   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

endpackage

/* hdl/vlbs_store.sv */
// Byte-wide single-port store holding the stacked records and length words.
// Depends on vlbs_pkg for its depth and the access struct.
`timescale 1ns / 1ps

module vlbs_store (
   input  logic                 clock,
   input  vlbs_pkg::mem_req_type mem_req,
   output logic [7:0]           rdata
);
   import vlbs_pkg::*;

   logic [7:0] mem [STACK_BYTES];
   logic [7:0] rdata_ff;

   // Synchronous write and registered read, one access per cycle.
   always_ff @(posedge clock) begin
      if (mem_req.en) begin
         if (mem_req.we) begin
            mem[mem_req.addr] <= mem_req.wdata;
         end else begin
            rdata_ff <= mem[mem_req.addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/variable_length_byte_stack_core.sv */
// Channel | direction | tdata (low bit up)                          | tuser
// req     | in        | element_bytes[63:0], length[67:64], pad 0s  | cmd[2:0]
// rsp     | out       | read_bytes[63:0], read_len[67:64],          | status[1:0]
//         |           | empty_res[68], pad 0s                       |
// One item at a time: push writes the record bytes and then the length word, pop and
// peek read the length byte and then the delivered data bytes, all through the single
// byte port of the store; each item also passes an accept step and a finish step.
// Clear, check and rejected commands go straight from accept to finish.
// Synchronous active-high reset empties the stack; the store needs no clearing pass.
// A waiting result does not block the next item; only a second result stalls.
// Top level of the variable-length record stack; depends on vlbs_pkg, vlbs_store
// and the assertion macros in variable_length_byte_stack_core_defines.svh.
`timescale 1ns / 1ps
`include "variable_length_byte_stack_core_defines.svh"

module variable_length_byte_stack_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // element_bytes[63:0], length[67:64], zero pad
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // read_bytes[63:0], read_len[67:64], empty_res[68]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import vlbs_pkg::*;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [LEN_W-1:0]  n_ff, n_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [STS_W-1:0]  status_ff, status_in;
   logic [DATA_W-1:0] rbytes_ff, rbytes_in;
   logic [LEN_W-1:0]  rlen_ff, rlen_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_bytes_ff, rsp_bytes_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_empty_ff, rsp_empty_in;

   mem_req_type mem_req;
   logic [7:0]  rdata;

   logic              req_fire;
   logic              rsp_free;
   logic [LEN_W-1:0]  req_len;
   logic              req_fits;
   logic              push_last;
   logic              data_done;
   logic [TOP_W-1:0]  wpos;
   logic [LEN_W-1:0]  stored_cap;
   logic [LEN_W-1:0]  stored;
   logic [LEN_W-1:0]  take;
   logic [7:0]        push_byte;
   logic [CNT_W-1:0]  word_idx;

   vlbs_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   // Handshake and shared decode terms.
   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_len  = req_tdata[67:64];
   assign req_fits = (req_len <= LEN_W'(MAX_RECORD_BYTES)) &&
                     ({1'b0, top_ff} + FIT_W'(req_len) + FIT_W'(LEN_WORD_BYTES)
                      <= FIT_W'(STACK_BYTES));

   // Push walks the record bytes, then the length word (low byte holds the length).
   assign push_last = (cnt_ff == CNT_W'(len_ff) + CNT_W'(LEN_WORD_BYTES - 1));
   assign word_idx  = cnt_ff - CNT_W'(len_ff);
   always_comb begin
      if (cnt_ff < CNT_W'(len_ff)) begin
         push_byte = data_ff[cnt_ff[IDX_W-1:0]*8 +: 8];
      end else if (word_idx == '0) begin
         push_byte = 8'(len_ff);
      end else begin
         push_byte = 8'd0;
      end
   end

   // Length word position and the clamped record length read back from it.
   assign wpos       = (top_ff >= TOP_W'(LEN_WORD_BYTES)) ?
                       top_ff - TOP_W'(LEN_WORD_BYTES) : '0;
   assign stored_cap = (rdata > 8'(MAX_RECORD_BYTES)) ?
                       LEN_W'(MAX_RECORD_BYTES) : rdata[LEN_W-1:0];
   assign stored     = (TOP_W'(stored_cap) > wpos) ? wpos[LEN_W-1:0] : stored_cap;
   assign take       = (len_ff < stored) ? len_ff : stored;
   assign data_done  = (cnt_ff == CNT_W'(n_ff)) && !pend_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == CMD_PUSH && req_fits) begin
                  state_in = ST_PUSH;
               end else if ((req_tuser == CMD_POP || req_tuser == CMD_PEEK) &&
                            top_ff != '0) begin
                  state_in = ST_LEN_RD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PUSH:     if (push_last) state_in = ST_FINISH;
         ST_LEN_RD:   state_in = ST_LEN_WAIT;
         ST_LEN_WAIT: state_in = ST_DATA;
         ST_DATA:     if (data_done) state_in = ST_FINISH;
         ST_FINISH:   if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: input ready and store accesses.
   always_comb begin
      req_tready = 1'b0;
      mem_req    = '0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_PUSH: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = ADDR_W'(top_ff + TOP_W'(cnt_ff));
            mem_req.wdata = push_byte;
         end
         ST_LEN_RD: begin
            mem_req.en   = 1'b1;
            mem_req.addr = ADDR_W'(wpos);
         end
         ST_DATA: begin
            mem_req.en   = (cnt_ff < CNT_W'(n_ff));
            mem_req.addr = base_ff + ADDR_W'(cnt_ff);
         end
         default: ;
      endcase
   end

   // Datapath registers' next values.
   always_comb begin
      cmd_in        = cmd_ff;
      data_in       = data_ff;
      len_in        = len_ff;
      top_in        = top_ff;
      cnt_in        = cnt_ff;
      base_in       = base_ff;
      n_in          = n_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      status_in     = status_ff;
      rbytes_in     = rbytes_ff;
      rlen_in       = rlen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_empty_in  = rsp_empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_tuser;
               data_in   = req_tdata[DATA_W-1:0];
               len_in    = req_len;
               cnt_in    = '0;
               status_in = STS_DONE;
               rbytes_in = '0;
               rlen_in   = '0;
               case (req_tuser) inside
                  CMD_PUSH:  if (!req_fits) status_in = STS_NO_ROOM;
                  CMD_POP, CMD_PEEK: if (top_ff == '0) status_in = STS_EMPTY;
                  CMD_CLEAR: top_in = '0;
                  CMD_CHECK: if (!req_fits) status_in = STS_NO_ROOM;
                  default: ;
               endcase
            end
         end
         ST_PUSH: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (push_last) begin
               top_in = top_ff + TOP_W'(len_ff) + TOP_W'(LEN_WORD_BYTES);
            end
         end
         ST_LEN_WAIT: begin
            base_in = ADDR_W'(wpos - TOP_W'(stored));
            n_in    = take;
            cnt_in  = '0;
         end
         ST_DATA: begin
            // Reads are pipelined: issue one byte, capture the previous one.
            if (cnt_ff < CNT_W'(n_ff)) begin
               pend_in = 1'b1;
               pidx_in = cnt_ff[IDX_W-1:0];
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               rbytes_in[pidx_ff*8 +: 8] = rdata;
            end
            if (data_done) begin
               rlen_in = n_ff;
               if (cmd_ff == CMD_POP) top_in = TOP_W'(base_ff);
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_bytes_in  = rbytes_ff;
               rsp_len_in    = rlen_ff;
               rsp_empty_in  = (top_ff == '0);
            end
         end
         default: ;
      endcase
   end

   // Control state is reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      data_ff       <= data_in;
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      base_ff       <= base_in;
      n_ff          <= n_in;
      pidx_ff       <= pidx_in;
      status_ff     <= status_in;
      rbytes_ff     <= rbytes_in;
      rlen_ff       <= rlen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // Result port.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_empty_ff, rsp_len_ff, rsp_bytes_ff};

   // The top never passes the end of the store.
   `VLBS_ASSERT_NOW(a_top_bound, clock, reset, 1'b1, top_ff <= TOP_W'(STACK_BYTES))
   // Only a push writes the store.
   `VLBS_ASSERT_NOW(a_write_push, clock, reset, mem_req.we, state_ff == ST_PUSH)
   // An outstanding data read always comes from the data read phase.
   `VLBS_ASSERT_NOW(a_pend_data, clock, reset, pend_ff, $past(state_ff) == ST_DATA)
   // An accepted item leaves the idle state at once.
   `VLBS_ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, state_ff != ST_IDLE)

endmodule

/* bench/variable_length_byte_stack_core_tb.sv */
// Self-checking testbench for the variable-length record stack core.
// Drives push, pop, peek, clear and fit checks over the item streams and checks
// every result against a predictor kept in step; depends on vlbs_pkg and the core.
`timescale 1ns / 1ps

module variable_length_byte_stack_core_tb;
   import vlbs_pkg::*;

   // Command codes that the block ignores.
   localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

   localparam int WATCHDOG_CYCLES = 5000;
   localparam int DRAIN_CYCLES    = 40;

   // One expected result, fields as they appear on the result stream.
   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic [DATA_W-1:0] read_bytes;
      logic [LEN_W-1:0]  read_len;
      logic              empty_res;
   } stack_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // element_bytes[63:0], length[67:64], zero pad
   logic [2:0]  req_tuser = '0;   // cmd[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // read_bytes[63:0], read_len[67:64], empty_res[68]
   logic [1:0]  rsp_tuser;        // status[1:0]

   // Predictor state: the byte store and the top of the stack.
   logic [7:0]       record_store [STACK_BYTES];
   int               record_top = 0;
   stack_result_type pending_results [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int results_checked = 0;
   int refused_count = 0;
   int peak_depth = 0;
   int cmd_count [8] = '{default: 0};

   variable_length_byte_stack_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Would a record of this length be accepted at the current top?
   function automatic bit record_fits(input logic [LEN_W-1:0] len);
      return (int'(len) <= MAX_RECORD_BYTES) &&
             (record_top + int'(len) + LEN_WORD_BYTES <= STACK_BYTES);
   endfunction

   // Apply one command to the predictor state and return the result it gives.
   function automatic stack_result_type predict_stack_result(
         input logic [CMD_W-1:0] cmd,
         input logic [DATA_W-1:0] data,
         input logic [LEN_W-1:0] len);
      stack_result_type res;
      int               wpos;
      int               stored;
      int               base;
      int               n;
      res = '0;
      case (cmd)
         CMD_PUSH: begin
            if (!record_fits(len)) begin
               res.status = STS_NO_ROOM;
            end else begin
               for (int i = 0; i < int'(len); i++)
                  record_store[record_top + i] = data[8*i +: 8];
               record_top += int'(len);
               // Length word follows the record, least significant byte first.
               for (int i = 0; i < LEN_WORD_BYTES; i++)
                  record_store[record_top + i] = 8'(32'(len) >> (8 * i));
               record_top += LEN_WORD_BYTES;
            end
         end
         CMD_POP, CMD_PEEK: begin
            if (record_top == 0) begin
               res.status = STS_EMPTY;
            end else begin
               wpos   = (record_top >= LEN_WORD_BYTES) ? record_top - LEN_WORD_BYTES : 0;
               stored = 0;
               for (int i = 0; i < LEN_WORD_BYTES; i++)
                  stored |= int'(record_store[wpos + i]) << (8 * i);
               if (stored > MAX_RECORD_BYTES) stored = MAX_RECORD_BYTES;
               if (stored > wpos) stored = wpos;
               base = wpos - stored;
               n    = (int'(len) < stored) ? int'(len) : stored;
               for (int i = 0; i < n; i++)
                  res.read_bytes[8*i +: 8] = record_store[base + i];
               res.read_len = LEN_W'(n);
               if (cmd == CMD_POP) record_top = base;
            end
         end
         CMD_CLEAR: record_top = 0;
         CMD_CHECK: res.status = record_fits(len) ? STS_DONE : STS_NO_ROOM;
         default: ;
      endcase
      res.empty_res = (record_top == 0);
      if (record_top > peak_depth) peak_depth = record_top;
      return res;
   endfunction

   // Offer one item, wait until it is taken and record what it should produce.
   // Entered and left at a falling edge; valid stays high between items unless
   // the sender decides to idle first.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data,
                            input logic [LEN_W-1:0] len);
      stack_result_type res;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, len, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = predict_stack_result(cmd, data, len);
      pending_results.push_back(res);
      cmd_count[cmd]++;
      if (res.status != STS_DONE) refused_count++;
      @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] random_bytes();
      return {$urandom, $urandom};
   endfunction

   // Wanted or record length: mostly legal, now and then beyond the maximum.
   function automatic logic [LEN_W-1:0] random_len();
      if ($urandom_range(99) < 10)
         return LEN_W'($urandom_range(15, MAX_RECORD_BYTES + 1));
      return LEN_W'($urandom_range(MAX_RECORD_BYTES));
   endfunction

   // Empty-stack refusals, length extremes, truncation and ignored commands.
   task automatic test_directed_cases();
      send_item(CMD_POP, random_bytes(), 4'd8);
      send_item(CMD_PEEK, random_bytes(), 4'd8);
      send_item(CMD_CHECK, random_bytes(), 4'd0);
      send_item(CMD_CHECK, random_bytes(), 4'd8);
      send_item(CMD_CHECK, random_bytes(), 4'd9);
      send_item(CMD_CHECK, random_bytes(), 4'd15);
      // An empty record still takes a length word.
      send_item(CMD_PUSH, random_bytes(), 4'd0);
      send_item(CMD_PEEK, random_bytes(), 4'd8);
      send_item(CMD_POP, random_bytes(), 4'd0);
      send_item(CMD_PUSH, '1, 4'd8);
      send_item(CMD_PUSH, '0, 4'd8);
      send_item(CMD_PUSH, random_bytes(), 4'd3);
      // Wanted length above the stored one, then below it.
      send_item(CMD_PEEK, random_bytes(), 4'd15);
      send_item(CMD_POP, random_bytes(), 4'd2);
      send_item(CMD_PEEK, random_bytes(), 4'd0);
      send_item(CMD_POP, random_bytes(), 4'd8);
      // Over-long records are refused as if there were no room.
      send_item(CMD_PUSH, random_bytes(), 4'd9);
      send_item(CMD_PUSH, '1, 4'd15);
      for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
         send_item(CMD_W'(c), random_bytes(), random_len());
      // Bytes of the data word beyond the length must not be stored.
      send_item(CMD_PUSH, '1, 4'd5);
      send_item(CMD_PEEK, random_bytes(), 4'd8);
      send_item(CMD_CLEAR, random_bytes(), random_len());
      send_item(CMD_PEEK, random_bytes(), 4'd8);
      send_item(CMD_CLEAR, random_bytes(), random_len());
   endtask

   // Fill the store as far as records allow, probe the boundary, then unwind.
   task automatic test_fill_and_overflow();
      int room;
      send_item(CMD_CLEAR, random_bytes(), random_len());
      while (record_top + MAX_RECORD_BYTES + LEN_WORD_BYTES <= STACK_BYTES)
         send_item(CMD_PUSH, random_bytes(), LEN_W'($urandom_range(MAX_RECORD_BYTES)));
      for (int len = 0; len <= MAX_RECORD_BYTES; len++) begin
         send_item(CMD_CHECK, random_bytes(), LEN_W'(len));
         send_item(CMD_PUSH, random_bytes(), LEN_W'(len));
      end
      // Use up the exact remainder where a record can still take it.
      room = STACK_BYTES - record_top - LEN_WORD_BYTES;
      if (room >= 0 && room <= MAX_RECORD_BYTES)
         send_item(CMD_PUSH, random_bytes(), LEN_W'(room));
      send_item(CMD_CHECK, random_bytes(), 4'd0);
      send_item(CMD_PUSH, random_bytes(), 4'd0);
      send_item(CMD_PEEK, random_bytes(), random_len());
      repeat (25) send_item(CMD_POP, random_bytes(), random_len());
      send_item(CMD_PUSH, random_bytes(), random_len());
      send_item(CMD_CLEAR, random_bytes(), random_len());
   endtask

   // Mixed traffic that lets the stack grow, shrink and empty again.
   task automatic test_random_traffic(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 42)
            send_item(CMD_PUSH, random_bytes(), random_len());
         else if (pick < 64)
            send_item(CMD_POP, random_bytes(), random_len());
         else if (pick < 80)
            send_item(CMD_PEEK, random_bytes(), random_len());
         else if (pick < 89)
            send_item(CMD_CHECK, random_bytes(), LEN_W'($urandom_range(15)));
         else if (pick < 94)
            send_item(CMD_CLEAR, random_bytes(), random_len());
         else
            send_item(CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST)),
                      random_bytes(), LEN_W'($urandom_range(15)));
      end
   endtask

   // Result receiver readiness, redrawn every cycle.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      stack_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result with no command waiting: tdata %h, tuser %h", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[63:0] !== want.read_bytes) begin
               $error("read_bytes: expected %h, got %h", want.read_bytes, rsp_tdata[63:0]);
               error_count++;
            end
            if (rsp_tdata[67:64] !== want.read_len) begin
               $error("read_len: expected %0d, got %0d", want.read_len, rsp_tdata[67:64]);
               error_count++;
            end
            if (rsp_tdata[68] !== want.empty_res) begin
               $error("empty_res: expected %0d, got %0d", want.empty_res, rsp_tdata[68]);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either stream.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("variable_length_byte_stack_core regression: fail");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Slow receiver.
      send_idle_pct = 11;
      recv_idle_pct = 56;
      test_directed_cases();
      test_random_traffic(170);

      // Slow sender.
      send_idle_pct = 56;
      recv_idle_pct = 11;
      test_fill_and_overflow();
      test_random_traffic(80);

      // Back to back on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(120);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d push, %0d pop, %0d peek, %0d clear, %0d check and %0d ignored commands.",
               cmd_count[CMD_PUSH], cmd_count[CMD_POP], cmd_count[CMD_PEEK],
               cmd_count[CMD_CLEAR], cmd_count[CMD_CHECK],
               cmd_count[5] + cmd_count[6] + cmd_count[7]);
      $display("%0d results checked, %0d refused, deepest stack %0d of %0d bytes, %0d errors.",
               results_checked, refused_count, peak_depth, STACK_BYTES, error_count);
      if (error_count == 0 && pending_results.size() == 0)
         $display("variable_length_byte_stack_core regression: pass");
      else
         $display("variable_length_byte_stack_core regression: fail");
      $finish;
   end

endmodule
